// ===== rtl/giom_pkg.sv =====
// shared types and constants of the greedy interval overlap matcher
package giom_pkg;

    localparam int TIME_W   = 32;
    localparam int SCORE_W  = 14;
    localparam int OVLTH_W  = 11;
    localparam int QIDX_W   = 16;
    localparam int SIDX_W   = 6;
    localparam int OP_W     = 2;
    localparam int CFG_AW   = 1;
    localparam int CFG_DW   = 14;
    localparam int IN_DW    = 80;
    localparam int OUT_DW   = 24;
    localparam int FRAC_W   = 10;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_SCORE_THR   = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_OVERLAP_THR = 1'd1;

    localparam logic [SCORE_W-1:0] SCORE_THR_RST   = 14'd5000;
    localparam logic [OVLTH_W-1:0] OVERLAP_THR_RST = 11'd184;

    typedef struct packed {
        logic               used;
        logic               nonempty;
        logic [SCORE_W-1:0] score;
        logic [TIME_W-1:0]  end_ms;
        logic [TIME_W-1:0]  start_ms;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/greedy_interval_overlap_matcher.sv =====
// Greedy interval overlap matcher. A clear beat starts a batch, load beats append secondary
// intervals to a table of TABLE_DEPTH entries held in one ram (loads into a full table are
// dropped), and each query beat scans the loaded entries and returns one result beat. During
// a query the table is read only while the scan phase bit is clear, because the running best
// ratio feeds the cross-multiplier of the next entry through a multiply stage and a compare
// stage. An ineligible query reads no entries. A new beat is taken while the previous result
// still waits on the output. The user must write configuration only while the block is idle;
// the block itself does not enforce this.
module greedy_interval_overlap_matcher
    import giom_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // interval_start[31:0], interval_end[63:32], interval_score[77:64],
    // interval_nonempty[78], zero pad[79]
    input  logic [IN_DW-1:0]    s_axis_tdata,
    // opcode[1:0]
    input  logic [OP_W-1:0]     s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // primary_index[15:0], matched[16], secondary_index[22:17], zero pad[23]
    output logic [OUT_DW-1:0]   m_axis_tdata,
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_DW-1:0]   cfg_wdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam int PROD_W = 2 * TIME_W;
    localparam int THR_W  = TIME_W + OVLTH_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_THR  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // control state
    logic [1:0]          state_reg, state_next;
    logic [CW-1:0]       entry_count_reg, entry_count_next;
    logic [QIDX_W-1:0]   query_count_reg, query_count_next;
    logic [CW-1:0]       issue_k_reg, issue_k_next;
    logic                phase_reg, phase_next;
    logic                q_elig_reg, q_elig_next;
    logic                v1_reg, v2_reg, v3_reg;
    logic                out_valid_reg, out_valid_next;
    logic [SCORE_W-1:0]  score_thr_reg;
    logic [OVLTH_W-1:0]  overlap_thr_reg;

    // payload
    logic [TIME_W-1:0]   q_start_reg, q_end_reg;
    logic [QIDX_W-1:0]   q_idx_reg;
    logic [AW-1:0]       a1_reg, idx2_reg, idx3_reg;
    logic [TIME_W-1:0]   ov2_reg, sp2_reg, ov3_reg, sp3_reg;
    logic                ok2_reg, ok3_reg;
    entry_t              ent2_reg, ent3_reg;
    logic [PROD_W-1:0]   prod_a_reg, prod_b_reg;
    logic [TIME_W-1:0]   best_ov_reg, best_sp_reg;
    logic [AW-1:0]       best_idx_reg;
    entry_t              best_ent_reg;
    logic [THR_W-1:0]    thr_prod_reg;
    logic [OUT_DW-1:0]   out_data_reg;

    // input fields
    logic [TIME_W-1:0]   in_start, in_end, in_end_raised;
    logic [SCORE_W-1:0]  in_score;
    logic                in_nonempty;
    logic                in_accept;

    // ram
    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    entry_t              ram_wdata, ram_rdata;

    // measure
    logic [TIME_W-1:0]   m_lo, m_hi, m_da, m_db, m_min, m_ov, m_sp;
    logic                m_ok;

    logic [PROD_W-1:0]   prod_a, prod_b;
    logic [THR_W-1:0]    thr_prod;
    logic                issue, scan_done, hit, fin_go;
    logic [AW+SIDX_W-1:0] sidx_ext;

    assign in_start      = s_axis_tdata[31:0];
    assign in_end        = s_axis_tdata[63:32];
    assign in_score      = s_axis_tdata[77:64];
    assign in_nonempty   = s_axis_tdata[78];
    assign in_end_raised = (in_end < in_start) ? in_start : in_end;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign issue     = (state_reg == ST_SCAN) && q_elig_reg && !phase_reg &&
                       (issue_k_reg < entry_count_reg);
    assign scan_done = !(q_elig_reg && (issue_k_reg < entry_count_reg)) &&
                       !v1_reg && !v2_reg && !v3_reg;

    // overlap and floored shorter span of query and entry
    always_comb
    begin
        m_lo  = (q_start_reg > ram_rdata.start_ms) ? q_start_reg : ram_rdata.start_ms;
        m_hi  = (q_end_reg < ram_rdata.end_ms) ? q_end_reg : ram_rdata.end_ms;
        m_da  = q_end_reg - q_start_reg;
        m_db  = ram_rdata.end_ms - ram_rdata.start_ms;
        m_min = (m_da < m_db) ? m_da : m_db;
        m_ov  = (m_hi > m_lo) ? (m_hi - m_lo) : '0;
        m_sp  = (m_min == '0) ? TIME_W'(1) : m_min;
        m_ok  = !ram_rdata.used && ram_rdata.nonempty && (ram_rdata.score <= score_thr_reg);
    end

    // cross products: new ratio ov/sp against running best
    assign prod_a   = PROD_W'(ov2_reg) * PROD_W'(best_sp_reg);
    assign prod_b   = PROD_W'(best_ov_reg) * PROD_W'(sp2_reg);
    assign thr_prod = THR_W'(overlap_thr_reg) * THR_W'(best_sp_reg);

    assign hit    = (best_ov_reg != '0) &&
                    ({1'b0, best_ov_reg, {FRAC_W{1'b0}}} >= thr_prod_reg);
    assign fin_go = (state_reg == ST_FIN) && (!out_valid_reg || m_axis_tready);

    assign sidx_ext = {{SIDX_W{1'b0}}, best_idx_reg};

    // ram port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = entry_count_reg[AW-1:0];
        ram_wdata = best_ent_reg;
        if (in_accept && (s_axis_tuser == OP_LOAD) && (entry_count_reg < DEPTH_C))
        begin
            ram_we             = 1'b1;
            ram_wdata.used     = 1'b0;
            ram_wdata.nonempty = in_nonempty;
            ram_wdata.score    = in_score;
            ram_wdata.end_ms   = in_end_raised;
            ram_wdata.start_ms = in_start;
        end
        else if (fin_go && hit)
        begin
            // mark the matched entry used
            ram_we         = 1'b1;
            ram_waddr      = best_idx_reg;
            ram_wdata.used = 1'b1;
        end
        ram_re    = issue;
        ram_raddr = issue_k_reg[AW-1:0];
    end

    giom_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        query_count_next = query_count_reg;
        issue_k_next     = issue_k_reg;
        phase_next       = phase_reg;
        q_elig_next      = q_elig_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (s_axis_tuser)
                        OP_CLEAR:
                        begin
                            entry_count_next = '0;
                            query_count_next = '0;
                        end
                        OP_LOAD:
                        begin
                            if (entry_count_reg < DEPTH_C)
                            begin
                                entry_count_next = entry_count_reg + CW'(1);
                            end
                        end
                        OP_QUERY:
                        begin
                            query_count_next = query_count_reg + QIDX_W'(1);
                            issue_k_next     = '0;
                            phase_next       = 1'b0;
                            q_elig_next      = in_nonempty && (in_score <= score_thr_reg);
                            state_next       = ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                phase_next = !phase_reg;
                if (issue)
                begin
                    issue_k_next = issue_k_reg + CW'(1);
                end
                if (scan_done)
                begin
                    state_next = ST_THR;
                end
            end
            ST_THR:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            query_count_reg <= '0;
            issue_k_reg     <= '0;
            phase_reg       <= 1'b0;
            q_elig_reg      <= 1'b0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
            score_thr_reg   <= SCORE_THR_RST;
            overlap_thr_reg <= OVERLAP_THR_RST;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            query_count_reg <= query_count_next;
            issue_k_reg     <= issue_k_next;
            phase_reg       <= phase_next;
            q_elig_reg      <= q_elig_next;
            v1_reg          <= issue;
            v2_reg          <= v1_reg;
            v3_reg          <= v2_reg;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                if (cfg_addr == CFG_SCORE_THR)
                begin
                    score_thr_reg <= cfg_wdata;
                end
                else if (cfg_addr == CFG_OVERLAP_THR)
                begin
                    overlap_thr_reg <= cfg_wdata[OVLTH_W-1:0];
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_accept && (s_axis_tuser == OP_QUERY))
        begin
            q_start_reg  <= in_start;
            q_end_reg    <= in_end_raised;
            q_idx_reg    <= query_count_reg;
            best_ov_reg  <= '0;
            best_sp_reg  <= TIME_W'(1);
            best_idx_reg <= '0;
        end
        else if (v3_reg && ok3_reg && (prod_a_reg > prod_b_reg))
        begin
            best_ov_reg  <= ov3_reg;
            best_sp_reg  <= sp3_reg;
            best_idx_reg <= idx3_reg;
            best_ent_reg <= ent3_reg;
        end
        if (issue)
        begin
            a1_reg <= issue_k_reg[AW-1:0];
        end
        if (v1_reg)
        begin
            ov2_reg  <= m_ov;
            sp2_reg  <= m_sp;
            ok2_reg  <= m_ok;
            ent2_reg <= ram_rdata;
            idx2_reg <= a1_reg;
        end
        if (v2_reg)
        begin
            prod_a_reg <= prod_a;
            prod_b_reg <= prod_b;
            ov3_reg    <= ov2_reg;
            sp3_reg    <= sp2_reg;
            ok3_reg    <= ok2_reg;
            ent3_reg   <= ent2_reg;
            idx3_reg   <= idx2_reg;
        end
        if (state_reg == ST_THR)
        begin
            thr_prod_reg <= thr_prod;
        end
        if (fin_go)
        begin
            out_data_reg <= {1'b0,
                             (hit ? sidx_ext[SIDX_W-1:0] : {SIDX_W{1'b0}}),
                             hit,
                             q_idx_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== rtl/giom_ram.sv =====
// generic simple dual-port ram with registered read
module giom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
